// File: rtl/core/jst_pkg.sv
package jst_pkg;

    // Table sizes.
    localparam int SLOT_COUNT = 8;
    localparam int RING_DEPTH = 8;

    localparam int SLOT_AW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int RING_AW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int IDX_W   = (SLOT_AW > RING_AW) ? SLOT_AW : RING_AW;
    localparam int PEND_W  = $clog2(SLOT_COUNT + 1);

    localparam int ID_W     = 32;
    localparam int WORD_W   = 32;
    localparam int CNT_W    = 4;
    localparam int CNT_MAX  = 15;

    // Stream widths: input data holds three 32-bit words, output data 102 bits
    // padded to 104.
    localparam int S_DATA_W = 96;
    localparam int S_USER_W = 4;
    localparam int M_DATA_W = 104;

    typedef enum logic [2:0] {
        CMD_SUBMIT   = 3'd0,
        CMD_STATUS   = 3'd1,
        CMD_DISPATCH = 3'd2,
        CMD_COMPLETE = 3'd3,
        CMD_PENDING  = 3'd4
    } jst_cmd_t;

    typedef enum logic [1:0] {
        JS_UNKNOWN = 2'd0,
        JS_QUEUED  = 2'd1,
        JS_RUNNING = 2'd2,
        JS_DONE    = 2'd3
    } jst_status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RING_RD,
        S_RING_CMP,
        S_RUN_CMP,
        S_SLOT_RD,
        S_SLOT_CMP,
        S_DISP_DONE,
        S_OUT
    } jst_state_t;

    // Clamp the occupancy count to the 4-bit result field.
    function automatic logic [CNT_W-1:0] sat_count(input logic [PEND_W-1:0] n);
        logic [CNT_W-1:0] r;
        if (int'(n) > CNT_MAX) begin
            r = CNT_W'(CNT_MAX);
        end else begin
            r = CNT_W'(n);
        end
        return r;
    endfunction

endpackage

// File: rtl/core/job_slot_tracker_core.sv
// Job slot tracker. Each item on the s_ channel carries a command in s_tuser and
// the operands in s_tdata; exactly one result item comes back on the m_ channel
// for every item taken. The block works on one item at a time: s_tready is high
// only while it is idle, and a result is held in the output register until the
// sink takes it. Submit, complete, pending and unused commands, a status query
// for id zero and a dispatch that starts nothing go straight to the output
// state; a dispatch that starts a job passes through S_DISP_DONE first, since it
// waits for the slot memory read. A status query walks the result ring, then
// the running id, then the slot table, through a single 32-bit equality
// comparator fed from one read port per memory: a valid entry is read and then
// compared, an empty entry is skipped without a compare, and the walk stops at
// the first hit. Slot and ring occupancy live in flip-flops that reset clears at
// once, so the block is ready out of reset with no clearing pass. Ids start at
// one, count up per submit that takes a slot, and skip zero when they wrap.
module job_slot_tracker_core
    import jst_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,

    input  logic                s_tvalid,
    output logic                s_tready,
    // [31:0] job_word, [63:32] query_id, [95:64] done_word
    input  logic [S_DATA_W-1:0] s_tdata,
    // [2:0] cmd, [3] job_valid
    input  logic [S_USER_W-1:0] s_tuser,

    output logic                m_tvalid,
    input  logic                m_tready,
    // [31:0] job_id, [63:32] dispatched_word, [65:64] job_status,
    // [97:66] result_word, [101:98] pending_count, [103:102] zero
    output logic [M_DATA_W-1:0] m_tdata
);

    // Sequencer state.
    jst_state_t state_reg, state_next;

    // Tracker state held in flip-flops.
    logic [SLOT_COUNT-1:0] slot_occ_reg;
    logic [RING_DEPTH-1:0] ring_vld_reg;
    logic [ID_W-1:0]       next_id_reg;
    logic [ID_W-1:0]       running_id_reg;
    logic [RING_AW-1:0]    ring_pos_reg;
    logic [PEND_W-1:0]     pend_reg;

    // Working registers of the current item.
    logic [ID_W-1:0]       qid_reg;
    logic [IDX_W-1:0]      scan_idx_reg;
    logic [SLOT_AW-1:0]    disp_idx_reg;

    // Result register.
    logic [ID_W-1:0]       out_id_reg;
    logic [WORD_W-1:0]     out_word_reg;
    jst_status_t           out_status_reg;
    logic [WORD_W-1:0]     out_result_reg;
    logic [CNT_W-1:0]      out_count_reg;

    // Memories: each entry holds {id, word}, written together.
    logic [ID_W+WORD_W-1:0] slot_mem [SLOT_COUNT];
    logic [ID_W+WORD_W-1:0] ring_mem [RING_DEPTH];
    logic [ID_W+WORD_W-1:0] slot_rdata_reg;
    logic [ID_W+WORD_W-1:0] ring_rdata_reg;
    logic [SLOT_AW-1:0]     slot_raddr;
    logic [RING_AW-1:0]     ring_raddr;

    // Input item fields.
    logic                  in_acc;
    jst_cmd_t              in_cmd;
    logic                  in_job_valid;
    logic [WORD_W-1:0]     in_job_word;
    logic [ID_W-1:0]       in_query_id;
    logic [WORD_W-1:0]     in_done_word;

    assign in_acc       = s_tvalid && s_tready;
    assign in_cmd       = jst_cmd_t'(s_tuser[2:0]);
    assign in_job_valid = s_tuser[3];
    assign in_job_word  = s_tdata[31:0];
    assign in_query_id  = s_tdata[63:32];
    assign in_done_word = s_tdata[95:64];

    // Lowest free and lowest occupied slot.
    logic               free_found, occ_found;
    logic [SLOT_AW-1:0] free_idx, occ_idx;

    always_comb begin
        free_found = 1'b0;
        free_idx   = '0;
        occ_found  = 1'b0;
        occ_idx    = '0;
        for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
            if (!slot_occ_reg[i]) begin
                free_found = 1'b1;
                free_idx   = SLOT_AW'(i);
            end else begin
                occ_found = 1'b1;
                occ_idx   = SLOT_AW'(i);
            end
        end
    end

    // Next id, stepping over zero on wrap.
    logic [ID_W-1:0] id_inc, id_step;
    assign id_inc  = next_id_reg + ID_W'(1);
    assign id_step = (id_inc == '0) ? ID_W'(1) : id_inc;

    // Scan position helpers.
    logic ring_last, slot_last, ring_cur_vld, slot_cur_occ;
    assign ring_last    = (scan_idx_reg == IDX_W'(RING_DEPTH - 1));
    assign slot_last    = (scan_idx_reg == IDX_W'(SLOT_COUNT - 1));
    assign ring_cur_vld = ring_vld_reg[scan_idx_reg[RING_AW-1:0]];
    assign slot_cur_occ = slot_occ_reg[scan_idx_reg[SLOT_AW-1:0]];

    // The shared comparator: the operand is chosen by the scan phase.
    logic [ID_W-1:0] cmp_a;
    logic            cmp_hit;

    always_comb begin
        unique case (state_reg)
            S_RING_CMP: cmp_a = ring_rdata_reg[ID_W+WORD_W-1:WORD_W];
            S_SLOT_CMP: cmp_a = slot_rdata_reg[ID_W+WORD_W-1:WORD_W];
            default:    cmp_a = running_id_reg;
        endcase
    end

    assign cmp_hit = (cmp_a == qid_reg);

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (in_acc) begin
                    if (in_cmd == CMD_STATUS && in_query_id != '0) begin
                        state_next = S_RING_RD;
                    end else if (in_cmd == CMD_DISPATCH && running_id_reg == '0
                                 && occ_found) begin
                        state_next = S_DISP_DONE;
                    end else begin
                        state_next = S_OUT;
                    end
                end
            end
            S_RING_RD: begin
                if (ring_cur_vld) begin
                    state_next = S_RING_CMP;
                end else if (ring_last) begin
                    state_next = S_RUN_CMP;
                end
            end
            S_RING_CMP: begin
                if (cmp_hit) begin
                    state_next = S_OUT;
                end else if (ring_last) begin
                    state_next = S_RUN_CMP;
                end else begin
                    state_next = S_RING_RD;
                end
            end
            S_RUN_CMP: begin
                state_next = cmp_hit ? S_OUT : S_SLOT_RD;
            end
            S_SLOT_RD: begin
                if (slot_cur_occ) begin
                    state_next = S_SLOT_CMP;
                end else if (slot_last) begin
                    state_next = S_OUT;
                end
            end
            S_SLOT_CMP: begin
                if (cmp_hit || slot_last) begin
                    state_next = S_OUT;
                end else begin
                    state_next = S_SLOT_RD;
                end
            end
            S_DISP_DONE: begin
                state_next = S_OUT;
            end
            S_OUT: begin
                if (m_tready) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Handshake outputs.
    always_comb begin
        s_tready = (state_reg == S_IDLE);
        m_tvalid = (state_reg == S_OUT);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Memory control.
    logic slot_we, ring_we;
    assign slot_we    = in_acc && in_cmd == CMD_SUBMIT && in_job_valid && free_found;
    assign ring_we    = in_acc && in_cmd == CMD_COMPLETE && running_id_reg != '0;
    assign slot_raddr = (state_reg == S_IDLE) ? occ_idx : scan_idx_reg[SLOT_AW-1:0];
    assign ring_raddr = scan_idx_reg[RING_AW-1:0];

    always_ff @(posedge aclk) begin
        if (slot_we) begin
            slot_mem[free_idx] <= {next_id_reg, in_job_word};
        end
        slot_rdata_reg <= slot_mem[slot_raddr];
    end

    always_ff @(posedge aclk) begin
        if (ring_we) begin
            ring_mem[ring_pos_reg] <= {running_id_reg, in_done_word};
        end
        ring_rdata_reg <= ring_mem[ring_raddr];
    end

    // Control state of the tracker.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slot_occ_reg   <= '0;
            ring_vld_reg   <= '0;
            next_id_reg    <= ID_W'(1);
            running_id_reg <= '0;
            ring_pos_reg   <= '0;
            pend_reg       <= '0;
        end else begin
            if (slot_we) begin
                slot_occ_reg[free_idx] <= 1'b1;
                next_id_reg            <= id_step;
                pend_reg               <= pend_reg + PEND_W'(1);
            end
            if (ring_we) begin
                ring_vld_reg[ring_pos_reg] <= 1'b1;
                running_id_reg             <= '0;
                if (ring_pos_reg == RING_AW'(RING_DEPTH - 1)) begin
                    ring_pos_reg <= '0;
                end else begin
                    ring_pos_reg <= ring_pos_reg + RING_AW'(1);
                end
            end
            if (state_reg == S_DISP_DONE) begin
                slot_occ_reg[disp_idx_reg] <= 1'b0;
                running_id_reg <= slot_rdata_reg[ID_W+WORD_W-1:WORD_W];
                pend_reg       <= pend_reg - PEND_W'(1);
            end
        end
    end

    // Working registers and the result register.
    always_ff @(posedge aclk) begin
        if (in_acc) begin
            qid_reg        <= in_query_id;
            disp_idx_reg   <= occ_idx;
            scan_idx_reg   <= '0;
            out_id_reg     <= '0;
            out_word_reg   <= '0;
            out_status_reg <= JS_UNKNOWN;
            out_result_reg <= '0;
            out_count_reg  <= '0;
            unique case (in_cmd)
                CMD_SUBMIT: begin
                    if (slot_we) begin
                        out_id_reg <= next_id_reg;
                    end
                end
                CMD_PENDING: begin
                    out_count_reg <= sat_count(pend_reg);
                end
                default: begin
                end
            endcase
        end else begin
            unique case (state_reg)
                S_RING_RD: begin
                    if (!ring_cur_vld) begin
                        scan_idx_reg <= ring_last ? '0 : scan_idx_reg + IDX_W'(1);
                    end
                end
                S_RING_CMP: begin
                    if (cmp_hit) begin
                        out_status_reg <= JS_DONE;
                        out_result_reg <= ring_rdata_reg[WORD_W-1:0];
                    end else begin
                        scan_idx_reg <= ring_last ? '0 : scan_idx_reg + IDX_W'(1);
                    end
                end
                S_RUN_CMP: begin
                    scan_idx_reg <= '0;
                    if (cmp_hit) begin
                        out_status_reg <= JS_RUNNING;
                    end
                end
                S_SLOT_RD: begin
                    if (!slot_cur_occ) begin
                        scan_idx_reg <= scan_idx_reg + IDX_W'(1);
                    end
                end
                S_SLOT_CMP: begin
                    if (cmp_hit) begin
                        out_status_reg <= JS_QUEUED;
                    end else begin
                        scan_idx_reg <= scan_idx_reg + IDX_W'(1);
                    end
                end
                S_DISP_DONE: begin
                    out_id_reg   <= slot_rdata_reg[ID_W+WORD_W-1:WORD_W];
                    out_word_reg <= slot_rdata_reg[WORD_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    assign m_tdata = {2'b00, out_count_reg, out_result_reg, out_status_reg,
                      out_word_reg, out_id_reg};

    // The pending counter always matches the occupancy bits.
    a_pend_matches_occ: assert property (@(posedge aclk) disable iff (!aresetn)
        pend_reg == PEND_W'($countones(slot_occ_reg)))
        else $error("pending counter out of step with slot occupancy");

    // Zero is never handed out as an id.
    a_next_id_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        next_id_reg != '0)
        else $error("next id reached zero");

    // A finished dispatch always leaves a job running.
    a_disp_sets_running: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_DISP_DONE |=> running_id_reg != '0)
        else $error("dispatch left no running job");

    // A dispatch is only started when no job runs.
    a_disp_only_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_DISP_DONE |-> $past(running_id_reg) == '0)
        else $error("dispatch started while a job was running");

    // A completion with a running job fills the ring entry it wrote.
    a_complete_fills_ring: assert property (@(posedge aclk) disable iff (!aresetn)
        ring_we |=> ring_vld_reg[$past(ring_pos_reg)] && running_id_reg == '0)
        else $error("completion did not record into the ring");

endmodule

// File: test/job_slot_tracker_tb.sv
module testbench
    import jst_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    // Command codes that the block does not implement; they must come back as all zero.
    localparam logic [2:0] CMD_UNUSED_FIRST = 3'd5;
    localparam logic [2:0] CMD_UNUSED_LAST  = 3'd7;

    localparam int DIR_ROWS       = 25;
    localparam int RANDOM_ITEMS   = 1150;
    // The tail after the last result allows for a full-length status query.
    localparam int TAIL_CYCLES    = 40;
    // The longest quiet stretch is the deliberate receiver hold-off plus one slow query.
    localparam int HOLDOFF_CYCLES = 300;
    localparam int HOLDOFF_AFTER  = 400;
    localparam int WATCHDOG_LIMIT = 2000;

    typedef struct packed {
        logic [2:0]  cmd;
        logic        job_valid;
        logic [31:0] job_word;
        logic [31:0] query_id;
        logic [31:0] done_word;
    } cmd_item_t;

    typedef struct packed {
        logic [31:0] job_id;
        logic [31:0] dispatched_word;
        jst_status_t job_status;
        logic [31:0] result_word;
        logic [3:0]  pending_count;
    } track_result_t;

    // A row of the directed table. Rows marked as typed expect an all-zero result except for
    // job_id, which is typed in as well; the other rows take their expectation from the predictor.
    typedef struct packed {
        cmd_item_t   item;
        bit          typed;
        logic [31:0] want_id;
    } dir_row_t;

    logic                aclk;
    logic                aresetn;
    logic                s_tvalid;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata;
    logic [S_USER_W-1:0] s_tuser;
    logic                m_tvalid;
    logic                m_tready;
    logic [M_DATA_W-1:0] m_tdata;

    job_slot_tracker_core dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // Shadow copy of the tracker state, advanced once per accepted item.
    logic [31:0] trk_slot_id  [SLOT_COUNT];
    logic [31:0] trk_slot_job [SLOT_COUNT];
    logic [31:0] trk_ring_id  [RING_DEPTH];
    logic [31:0] trk_ring_res [RING_DEPTH];
    logic [31:0] trk_next_id;
    int          trk_ring_pos;
    logic [31:0] trk_running;

    // Results still owed by the block, oldest first.
    track_result_t pending_results[$];
    // Ids handed out recently, used to aim status queries at jobs that exist.
    logic [31:0]   issued_ids[$];

    dir_row_t      dir_tab[DIR_ROWS];
    track_result_t got_res;
    track_result_t want_res;

    int errors;
    int items_sent;
    int results_seen;
    int stall_cycles;
    int burst_left;
    int n_ids_given;
    int n_full_refused;
    int n_completed;
    int n_done_answers;
    bit holdoff_done;

    initial begin
        aclk = 1'b0;
    end

    always #5 aclk = ~aclk;

    // Wipes the shadow state the same way reset clears the block.
    task automatic tracker_clear();
        for (int i = 0; i < SLOT_COUNT; i++) begin
            trk_slot_id[i]  = '0;
            trk_slot_job[i] = '0;
        end
        for (int i = 0; i < RING_DEPTH; i++) begin
            trk_ring_id[i]  = '0;
            trk_ring_res[i] = '0;
        end
        trk_next_id  = 32'd1;
        trk_ring_pos = 0;
        trk_running  = '0;
    endtask

    // Computes the result of one command and updates the shadow state.
    function automatic track_result_t predict_tracker(cmd_item_t it);
        track_result_t r;
        bit            hit;
        int            pos;
        int            cnt;
        r.job_id          = '0;
        r.dispatched_word = '0;
        r.job_status      = JS_UNKNOWN;
        r.result_word     = '0;
        r.pending_count   = '0;
        hit = 1'b0;
        cnt = 0;
        case (it.cmd)
            CMD_SUBMIT: begin
                // The job lands in the lowest free slot; a full table or a missing job
                // leaves everything untouched.
                if (it.job_valid) begin
                    for (int i = 0; i < SLOT_COUNT; i++) begin
                        if (!hit && trk_slot_id[i] == '0) begin
                            hit             = 1'b1;
                            r.job_id        = trk_next_id;
                            trk_slot_id[i]  = trk_next_id;
                            trk_slot_job[i] = it.job_word;
                            trk_next_id     = trk_next_id + 32'd1;
                            if (trk_next_id == '0) begin
                                trk_next_id = 32'd1;
                            end
                        end
                    end
                end
            end
            CMD_STATUS: begin
                // The ring is searched first, then the running job, then the slots.
                if (it.query_id != '0) begin
                    for (int i = 0; i < RING_DEPTH; i++) begin
                        if (!hit && trk_ring_id[i] == it.query_id) begin
                            hit           = 1'b1;
                            r.job_status  = JS_DONE;
                            r.result_word = trk_ring_res[i];
                        end
                    end
                    if (!hit && trk_running == it.query_id) begin
                        hit          = 1'b1;
                        r.job_status = JS_RUNNING;
                    end
                    for (int i = 0; i < SLOT_COUNT; i++) begin
                        if (!hit && trk_slot_id[i] == it.query_id) begin
                            hit          = 1'b1;
                            r.job_status = JS_QUEUED;
                        end
                    end
                end
            end
            CMD_DISPATCH: begin
                // Only one job runs at a time; the lowest occupied slot goes next.
                if (trk_running == '0) begin
                    for (int i = 0; i < SLOT_COUNT; i++) begin
                        if (!hit && trk_slot_id[i] != '0) begin
                            hit               = 1'b1;
                            r.job_id          = trk_slot_id[i];
                            r.dispatched_word = trk_slot_job[i];
                            trk_running       = trk_slot_id[i];
                            trk_slot_id[i]    = '0;
                            trk_slot_job[i]   = '0;
                        end
                    end
                end
            end
            CMD_COMPLETE: begin
                if (trk_running != '0) begin
                    pos               = trk_ring_pos % RING_DEPTH;
                    trk_ring_id[pos]  = trk_running;
                    trk_ring_res[pos] = it.done_word;
                    trk_ring_pos      = (pos + 1) % RING_DEPTH;
                    trk_running       = '0;
                end
            end
            CMD_PENDING: begin
                for (int i = 0; i < SLOT_COUNT; i++) begin
                    if (trk_slot_id[i] != '0) begin
                        cnt++;
                    end
                end
                r.pending_count = (cnt > CNT_MAX) ? 4'(CNT_MAX) : 4'(cnt);
            end
            default: begin
            end
        endcase
        return r;
    endfunction

    function automatic dir_row_t row(logic [2:0] c, logic v, logic [31:0] jw, logic [31:0] qid,
                                     logic [31:0] dw, bit typed, logic [31:0] wid);
        dir_row_t d;
        d.item.cmd       = c;
        d.item.job_valid = v;
        d.item.job_word  = jw;
        d.item.query_id  = qid;
        d.item.done_word = dw;
        d.typed          = typed;
        d.want_id        = wid;
        return d;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch on result %0d: %s is %h, expected %h", results_seen, what, got, want);
        errors++;
    endtask

    // Offers one item on the input channel and records what it should produce once it is taken.
    // The sender works in bursts; between bursts it drops tvalid for a random gap, and some
    // bursts follow each other with no gap at all.
    task automatic offer_item(cmd_item_t it, bit typed, logic [31:0] want_id);
        track_result_t exp_res;
        int            gap;
        logic [31:0]   run_before;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= {it.done_word, it.query_id, it.job_word};
        s_tuser  <= {it.job_valid, it.cmd};
        @(posedge aclk);
        while (!s_tready) begin
            @(posedge aclk);
        end
        run_before = trk_running;
        exp_res = predict_tracker(it);
        if (typed) begin
            exp_res.job_id          = want_id;
            exp_res.dispatched_word = '0;
            exp_res.job_status      = JS_UNKNOWN;
            exp_res.result_word     = '0;
            exp_res.pending_count   = '0;
        end
        if (it.cmd == CMD_SUBMIT && it.job_valid) begin
            if (exp_res.job_id != '0) begin
                n_ids_given++;
                issued_ids.push_back(exp_res.job_id);
                if (issued_ids.size() > 40) begin
                    void'(issued_ids.pop_front());
                end
            end else begin
                n_full_refused++;
            end
        end
        if (it.cmd == CMD_COMPLETE && run_before != '0) begin
            n_completed++;
        end
        if (exp_res.job_status == JS_DONE) begin
            n_done_answers++;
        end
        pending_results.push_back(exp_res);
        items_sent++;
    endtask

    // Builds one random item. Phases lean toward filling the table, toward draining it, or
    // neither, so that the full table, the running job and ring wrap-around all come up often.
    function automatic cmd_item_t random_item(int lean);
        cmd_item_t it;
        int        pick;
        int        w_submit;
        int        w_drain;
        it.cmd       = CMD_PENDING;
        it.job_valid = 1'($urandom());
        it.job_word  = $urandom();
        it.query_id  = $urandom();
        it.done_word = $urandom();
        w_submit = (lean == 1) ? 50 : ((lean == 2) ? 10 : 30);
        w_drain  = (60 - w_submit) / 2;
        pick     = $urandom_range(0, 99);
        if (pick < w_submit) begin
            it.cmd       = CMD_SUBMIT;
            it.job_valid = ($urandom_range(0, 9) != 0);
        end else if (pick < w_submit + 25) begin
            it.cmd = CMD_STATUS;
            case ($urandom_range(0, 9))
                0: it.query_id = '0;
                1: it.query_id = trk_next_id;
                2: begin
                end
                default: begin
                    if (issued_ids.size() > 0) begin
                        it.query_id = issued_ids[$urandom_range(0, issued_ids.size() - 1)];
                    end
                end
            endcase
        end else if (pick < w_submit + 25 + w_drain) begin
            it.cmd = CMD_DISPATCH;
        end else if (pick < w_submit + 25 + 2 * w_drain) begin
            it.cmd = CMD_COMPLETE;
        end else if (pick < 95) begin
            it.cmd = CMD_PENDING;
        end else begin
            it.cmd = 3'($urandom_range(CMD_UNUSED_FIRST, CMD_UNUSED_LAST));
        end
        return it;
    endfunction

    // Result checker: every result taken is compared field by field with the oldest expectation.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected result, job_id", m_tdata[31:0], '0);
            end else begin
                want_res = pending_results.pop_front();
                if (m_tdata[31:0] !== want_res.job_id) begin
                    report_mismatch("job_id", m_tdata[31:0], want_res.job_id);
                end
                if (m_tdata[63:32] !== want_res.dispatched_word) begin
                    report_mismatch("dispatched_word", m_tdata[63:32], want_res.dispatched_word);
                end
                if (m_tdata[65:64] !== want_res.job_status) begin
                    report_mismatch("job_status", 32'(m_tdata[65:64]), 32'(want_res.job_status));
                end
                if (m_tdata[97:66] !== want_res.result_word) begin
                    report_mismatch("result_word", m_tdata[97:66], want_res.result_word);
                end
                if (m_tdata[101:98] !== want_res.pending_count) begin
                    report_mismatch("pending_count", 32'(m_tdata[101:98]),
                                    32'(want_res.pending_count));
                end
            end
            results_seen++;
        end
    end

    // Watchdog: ends the run if no item moves on either channel for too long.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            stall_cycles = 0;
        end else begin
            stall_cycles++;
            if (stall_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog: no item moved for %0d cycles, %0d results outstanding",
                         stall_cycles, pending_results.size());
                $display("status: fail");
                $finish;
            end
        end
    end

    // Receiver: switches between stall patterns of its own, and once, well into the run,
    // holds off completely so that a result sits in the output register and the block
    // refuses further input while the sender keeps offering.
    initial begin
        int mode;
        int mode_left;
        int cyc;
        mode      = 0;
        mode_left = 0;
        cyc       = 0;
        m_tready  = 1'b0;
        @(posedge aclk);
        while (!aresetn) begin
            @(posedge aclk);
        end
        forever begin
            @(posedge aclk);
            cyc++;
            if (!holdoff_done && items_sent >= HOLDOFF_AFTER) begin
                m_tready <= 1'b0;
                repeat (HOLDOFF_CYCLES) @(posedge aclk);
                holdoff_done = 1'b1;
            end
            if (mode_left == 0) begin
                mode      = $urandom_range(0, 3);
                mode_left = $urandom_range(10, 150);
            end
            mode_left--;
            case (mode)
                0: m_tready <= 1'b1;
                1: m_tready <= 1'($urandom());
                2: m_tready <= (cyc % 4 == 0);
                default: m_tready <= ($urandom_range(0, 7) == 0);
            endcase
        end
    end

    // Stimulus: reset, the directed table, then random items, then drain and report.
    initial begin
        cmd_item_t it;
        int        lean;
        errors         = 0;
        items_sent     = 0;
        results_seen   = 0;
        stall_cycles   = 0;
        burst_left     = 0;
        n_ids_given    = 0;
        n_full_refused = 0;
        n_completed    = 0;
        n_done_answers = 0;
        holdoff_done   = 1'b0;
        lean           = 0;
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = '0;
        tracker_clear();

        // After reset: every query of an empty tracker comes back as zero, and the first id is one.
        dir_tab[0]  = row(CMD_PENDING,  1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                          1'b1, 32'd0);
        // Query for id zero is always unknown.
        dir_tab[1]  = row(CMD_STATUS,   1'b1, 32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF, 1'b1, 32'd0);
        // Nothing queued, so dispatch gives nothing.
        dir_tab[2]  = row(CMD_DISPATCH, 1'b0, 32'h0, 32'h0, 32'h0, 1'b1, 32'd0);
        // Completion with no running job is ignored.
        dir_tab[3]  = row(CMD_COMPLETE, 1'b1, 32'h0, 32'h0, 32'hFFFF_FFFF, 1'b1, 32'd0);
        // A submit without a job is refused.
        dir_tab[4]  = row(CMD_SUBMIT,   1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                          1'b1, 32'd0);
        dir_tab[5]  = row(CMD_SUBMIT,   1'b1, 32'h0, 32'hFFFF_FFFF, 32'h0, 1'b1, 32'd1);
        dir_tab[6]  = row(CMD_SUBMIT,   1'b1, 32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF, 1'b0, 32'd0);
        dir_tab[7]  = row(CMD_SUBMIT,   1'b1, 32'h8000_0001, 32'h1, 32'h0, 1'b0, 32'd0);
        dir_tab[8]  = row(CMD_SUBMIT,   1'b1, 32'h1234_5678, 32'h0, 32'h0, 1'b0, 32'd0);
        dir_tab[9]  = row(CMD_SUBMIT,   1'b1, 32'h0000_0001, 32'h0, 32'h0, 1'b0, 32'd0);
        dir_tab[10] = row(CMD_SUBMIT,   1'b1, 32'hFFFF_FFFE, 32'h0, 32'h0, 1'b0, 32'd0);
        dir_tab[11] = row(CMD_SUBMIT,   1'b1, 32'h5A5A_A5A5, 32'h0, 32'h0, 1'b0, 32'd0);
        dir_tab[12] = row(CMD_SUBMIT,   1'b1, 32'hC3C3_3C3C, 32'h0, 32'h0, 1'b0, 32'd0);
        // All eight slots are taken now, so the next submit is refused.
        dir_tab[13] = row(CMD_SUBMIT,   1'b1, 32'hDEAD_0000, 32'h0, 32'h0, 1'b1, 32'd0);
        dir_tab[14] = row(CMD_PENDING,  1'b0, 32'h0, 32'h0, 32'h0, 1'b0, 32'd0);
        dir_tab[15] = row(CMD_STATUS,   1'b0, 32'h0, 32'h1, 32'h0, 1'b0, 32'd0);
        dir_tab[16] = row(CMD_DISPATCH, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                          1'b0, 32'd0);
        // A job is running, so a second dispatch is refused.
        dir_tab[17] = row(CMD_DISPATCH, 1'b0, 32'h0, 32'h0, 32'h0, 1'b1, 32'd0);
        dir_tab[18] = row(CMD_STATUS,   1'b0, 32'h0, 32'h1, 32'h0, 1'b0, 32'd0);
        dir_tab[19] = row(CMD_COMPLETE, 1'b0, 32'h0, 32'h0, 32'hFFFF_FFFF, 1'b0, 32'd0);
        dir_tab[20] = row(CMD_STATUS,   1'b0, 32'h0, 32'h1, 32'h0, 1'b0, 32'd0);
        // An id that was never handed out is unknown.
        dir_tab[21] = row(CMD_STATUS,   1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                          1'b1, 32'd0);
        // Unused command codes do nothing and answer with zeros.
        dir_tab[22] = row(CMD_UNUSED_FIRST, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                          1'b1, 32'd0);
        dir_tab[23] = row(CMD_UNUSED_LAST,  1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                          1'b1, 32'd0);
        // The freed lowest slot is reused by the next submit.
        dir_tab[24] = row(CMD_SUBMIT,   1'b1, 32'h0F0F_F0F0, 32'h0, 32'h0, 1'b0, 32'd0);

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int r = 0; r < DIR_ROWS; r++) begin
            offer_item(dir_tab[r].item, dir_tab[r].typed, dir_tab[r].want_id);
        end

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 100 == 0) begin
                lean = $urandom_range(0, 2);
            end
            it = random_item(lean);
            offer_item(it, 1'b0, 32'd0);
        end
        s_tvalid <= 1'b0;

        while (pending_results.size() != 0) begin
            @(posedge aclk);
        end
        repeat (TAIL_CYCLES) @(posedge aclk);

        $display("covered %0d items and %0d results: %0d ids handed out, %0d submits refused",
                 items_sent, results_seen, n_ids_given, n_full_refused);
        $display("%0d jobs completed, %0d status queries answered as done, %0d mismatches",
                 n_completed, n_done_answers, errors);
        if (errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

// File: sim.f
rtl/core/jst_pkg.sv
rtl/core/job_slot_tracker_core.sv
test/job_slot_tracker_tb.sv
